[src/indexed_deque_macros.svh]
// Assertion helpers for the indexed deque.
`ifndef INDEXED_DEQUE_MACROS_SVH
`define INDEXED_DEQUE_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define IDQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("indexed_deque check failed");

// Next-cycle implication, quiet during reset.
`define IDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("indexed_deque check failed");

`endif

[src/idq_pkg.sv]
`timescale 1ns / 1ps

package idq_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 4;
  localparam int ACT_W    = 3;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CMP_W    = (COUNT_W > POS_W) ? COUNT_W : POS_W;

  localparam logic signed [DATA_W-1:0] ERR_VALUE = 32'sh7FFF_FFFF;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_TAKE_AT    = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What every cell does at a clock edge.
  typedef enum logic [1:0] {
    CELL_HOLD     = 2'd0,
    CELL_SHIFT_IN = 2'd1,  // take left neighbor; cell 0 takes the new word
    CELL_LOAD     = 2'd2,  // cell at idx takes the new word
    CELL_CLOSE    = 2'd3   // cells at or above idx take right neighbor
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic [IDX_W-1:0]          idx;
    logic signed [DATA_W-1:0]  value;
  } cell_ctl_t;

endpackage

[src/indexed_deque.sv]
`timescale 1ns / 1ps
// Bounded double-ended queue of signed 32-bit words with removal by position.
// Command channel: drive action, value and position with start high; the
// request is taken at a rising edge where start is high and busy is low.
// busy is high only while rst is asserted, so one request can be taken
// every cycle.
// Result channel: done pulses for one cycle, in the cycle after the request is
// taken, with removed_value, status and count (element count after the
// request). The receiver cannot stall; each result is valid for that single
// cycle only.
// Storage is a row of cells with cell 0 at the front. All cells shift
// together at the same clock edge, and the result is held in output
// registers fed from the cell row.
// Reset clears the element count and the result strobe; cell contents are
// left as they are and are only read below the count.
`include "indexed_deque_macros.svh"

module indexed_deque import idq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [ACT_W-1:0]         action,
  input  logic signed [DATA_W-1:0] value,
  input  logic [POS_W-1:0]         position,
  output logic                     done,
  output logic signed [DATA_W-1:0] removed_value,
  output logic [STAT_W-1:0]        status,
  output logic [COUNT_W-1:0]       count
);

  logic                     accept;
  logic [COUNT_W-1:0]       occ;
  logic [COUNT_W-1:0]       occ_next;
  cell_ctl_t                ctl;
  logic [IDX_W-1:0]         take_idx;
  logic                     take_ok;
  logic signed [DATA_W-1:0] res_value;
  status_t                  res_status;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];

  assign busy   = rst;
  assign accept = start && !busy;

  always_comb begin
    ctl        = '{op: CELL_HOLD, idx: '0, value: value};
    take_idx   = '0;
    take_ok    = 1'b0;
    res_value  = '0;
    res_status = ST_OK;
    occ_next   = occ;
    if (accept) begin
      case (action)
        ACT_PUSH_FRONT: begin
          if (occ >= COUNT_W'(CAPACITY)) begin
            res_status = ST_FULL;
          end else begin
            ctl.op   = CELL_SHIFT_IN;
            occ_next = occ + COUNT_W'(1);
          end
        end
        ACT_PUSH_BACK: begin
          if (occ >= COUNT_W'(CAPACITY)) begin
            res_status = ST_FULL;
          end else begin
            ctl.op   = CELL_LOAD;
            ctl.idx  = IDX_W'(occ);
            occ_next = occ + COUNT_W'(1);
          end
        end
        ACT_POP_FRONT: begin
          take_ok  = (occ != '0);
          take_idx = '0;
        end
        ACT_POP_BACK: begin
          take_ok  = (occ != '0);
          take_idx = IDX_W'(occ - COUNT_W'(1));
        end
        ACT_TAKE_AT: begin
          take_ok  = CMP_W'(position) < CMP_W'(occ);
          take_idx = IDX_W'(position);
        end
        default: res_status = ST_OK;
      endcase
      if (action == ACT_POP_FRONT || action == ACT_POP_BACK || action == ACT_TAKE_AT) begin
        if (take_ok) begin
          ctl.op    = CELL_CLOSE;
          ctl.idx   = take_idx;
          res_value = cell_data[take_idx];
          occ_next  = occ - COUNT_W'(1);
        end else begin
          res_value  = ERR_VALUE;
          res_status = ST_EMPTY;
        end
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_in;
    logic signed [DATA_W-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = value;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = cell_data[i];
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end
    idq_cell u_cell (
      .clk   (clk),
      .idx   (IDX_W'(i)),
      .ctl   (ctl),
      .left  (left_in),
      .right (right_in),
      .data  (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ  <= '0;
      done <= 1'b0;
    end else begin
      occ  <= occ_next;
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    removed_value <= res_value;
    status        <= res_status;
    count         <= occ_next;
  end

  `IDQ_ASSERT_NEXT(a_done_follows, accept, done)
  `IDQ_ASSERT_NEXT(a_no_stray_done, !accept, !done)
  `IDQ_ASSERT_NOW(a_occ_bound, 1'b1, occ <= COUNT_W'(CAPACITY))
  `IDQ_ASSERT_NOW(a_full_at_cap, done && status == ST_FULL, count == COUNT_W'(CAPACITY))
  `IDQ_ASSERT_NOW(a_err_value, done && status == ST_EMPTY, removed_value == ERR_VALUE)
  `IDQ_ASSERT_NEXT(a_occ_step, accept,
    occ == $past(occ) || occ == $past(occ) + COUNT_W'(1) || occ == $past(occ) - COUNT_W'(1))

endmodule

[src/idq_cell.sv]
`timescale 1ns / 1ps

module idq_cell import idq_pkg::*; (
  input  logic                     clk,
  input  logic [IDX_W-1:0]         idx,
  input  cell_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] left,
  input  logic signed [DATA_W-1:0] right,
  output logic signed [DATA_W-1:0] data
);

  logic signed [DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (ctl.op)
      CELL_SHIFT_IN: data_next = left;
      CELL_LOAD: begin
        if (idx == ctl.idx) data_next = ctl.value;
      end
      CELL_CLOSE: begin
        if (idx >= ctl.idx) data_next = right;
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
